FILE: rtl/core/bdlb_pkg.sv
// Package for the button debounce and LED blink block.
// Holds the item structs, opcodes and timing masks; no dependencies.
package bdlb_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = 3;

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  localparam logic RegActiveLevel = 1'b0;

  localparam logic [4:0] CheckMask = 5'h1f;
  localparam logic [5:0] StepMask  = 6'h3f;
  localparam logic [31:0] SampleSpanMs = 32'd32;

  typedef struct packed {
    logic        op;
    logic        button_level;
    logic [31:0] pattern_value;
  } in_t;

  typedef struct packed {
    logic        pin_as_input;
    logic        pin_level;
    logic        button_down;
    logic [31:0] duration_ms;
    logic [31:0] previous_duration_ms;
  } out_t;

endpackage

FILE: rtl/core/bdlb_state.sv
// State registers and next-state logic of the debounce and blink block.
// Depends on bdlb_pkg; updates on each accepted item and returns its result.
module bdlb_state #(
  parameter int unsigned PATTERN_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  bdlb_pkg::in_t item_i,
  input  logic          active_level_i,
  output bdlb_pkg::out_t result_o
);
  import bdlb_pkg::*;

  logic [31:0]             ms_counter_q, ms_counter_d;
  logic                    check_armed_q, check_armed_d;
  logic                    step_armed_q, step_armed_d;
  logic                    last_sample_q, last_sample_d;
  logic                    debounced_down_q, debounced_down_d;
  logic [31:0]             state_start_q, state_start_d;
  logic [31:0]             cur_dur_q, cur_dur_d;
  logic [31:0]             prev_dur_q, prev_dur_d;
  logic                    led_level_q, led_level_d;
  logic [PATTERN_BITS-1:0] pattern_q, pattern_d;
  logic                    input_mode_q, input_mode_d;

  logic [31:0] now;
  logic [63:0] pattern_ext;
  logic        pressed;
  logic        skip_step;

  assign now         = ms_counter_q + 32'd1;
  assign pattern_ext = {32'd0, item_i.pattern_value};
  assign pressed     = (item_i.button_level == active_level_i);

  always_comb begin
    ms_counter_d     = ms_counter_q;
    check_armed_d    = check_armed_q;
    step_armed_d     = step_armed_q;
    last_sample_d    = last_sample_q;
    debounced_down_d = debounced_down_q;
    state_start_d    = state_start_q;
    cur_dur_d        = cur_dur_q;
    prev_dur_d       = prev_dur_q;
    led_level_d      = led_level_q;
    pattern_d        = pattern_q;
    input_mode_d     = input_mode_q;
    skip_step        = 1'b0;
    if (item_i.op == OpLoad) begin
      pattern_d = pattern_ext[PATTERN_BITS-1:0];
    end else begin
      ms_counter_d = now;
      if (check_armed_q && ((now[4:0] & CheckMask) == 5'd0)) begin
        check_armed_d = 1'b0;
        input_mode_d  = 1'b1;
        if (pressed != last_sample_q) begin
          last_sample_d = pressed;
          skip_step     = 1'b1;
        end else begin
          if (debounced_down_q != pressed) begin
            debounced_down_d = pressed;
            prev_dur_d       = cur_dur_q + SampleSpanMs;
            state_start_d    = now;
            cur_dur_d        = 32'd0;
          end else begin
            cur_dur_d = now - state_start_q;
          end
          input_mode_d = 1'b0;
        end
      end else if ((now[4:0] & CheckMask) != 5'd0) begin
        check_armed_d = 1'b1;
      end
      if (!skip_step) begin
        if (step_armed_q && ((now[5:0] & StepMask) == 6'd0)) begin
          led_level_d  = pattern_q[0] ? active_level_i : !active_level_i;
          pattern_d    = {pattern_q[0], pattern_q[PATTERN_BITS-1:1]};
          step_armed_d = 1'b0;
        end else if ((now[5:0] & StepMask) != 6'd0) begin
          step_armed_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result_o.pin_as_input         = input_mode_d;
    result_o.pin_level            = input_mode_d | led_level_d;
    result_o.button_down          = debounced_down_d;
    result_o.duration_ms          = cur_dur_d;
    result_o.previous_duration_ms = prev_dur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_counter_q     <= '0;
      check_armed_q    <= 1'b0;
      step_armed_q     <= 1'b0;
      last_sample_q    <= 1'b0;
      debounced_down_q <= 1'b0;
      state_start_q    <= '0;
      cur_dur_q        <= '0;
      prev_dur_q       <= '0;
      led_level_q      <= 1'b0;
      pattern_q        <= '0;
      input_mode_q     <= 1'b0;
    end else if (accept_i) begin
      ms_counter_q     <= ms_counter_d;
      check_armed_q    <= check_armed_d;
      step_armed_q     <= step_armed_d;
      last_sample_q    <= last_sample_d;
      debounced_down_q <= debounced_down_d;
      state_start_q    <= state_start_d;
      cur_dur_q        <= cur_dur_d;
      prev_dur_q       <= prev_dur_d;
      led_level_q      <= led_level_d;
      pattern_q        <= pattern_d;
      input_mode_q     <= input_mode_d;
    end
  end

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (item_i.op == OpTick) |=> ms_counter_q == $past(ms_counter_q) + 32'd1)
    else $error("tick item did not advance the millisecond counter");

  a_load_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (item_i.op == OpLoad) |=> $stable(ms_counter_q) && $stable(input_mode_q))
    else $error("load item changed timing or pin state");

  a_check_off_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_armed_q |-> ms_counter_q[4:0] != 5'd0)
    else $error("sample armed while sitting on a sample boundary");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(pattern_q) && $stable(debounced_down_q))
    else $error("state changed without an accepted item");

endmodule

FILE: rtl/core/button_debounce_led_blink.sv
// Top level: each accepted item yields one result item, registered in the cycle after it is taken.
// Throughput is one item per cycle while the output is not stalled; the output register is the only stage.
// The input is taken while a result waits, as long as that result leaves now.
// Reset clears all state but the output item register; active_level resets to 1 and the LED state to low.
// Depends on bdlb_pkg and bdlb_state.
module button_debounce_led_blink #(
  parameter int unsigned PATTERN_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bdlb_pkg::in_t                  in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bdlb_pkg::out_t                 out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdlb_pkg::AddrWidth-1:0] paddr,
  input  logic [bdlb_pkg::DataWidth-1:0] pwdata,
  output logic [bdlb_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import bdlb_pkg::*;

  logic active_level_q;
  logic out_valid_q;
  out_t out_item_q;
  out_t result;
  logic accept;
  logic cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready && (paddr[2] == RegActiveLevel);
  assign prdata     = (paddr[2] == RegActiveLevel) ? {31'd0, active_level_q} : '0;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= 1'b1;
    end else if (cfg_write) begin
      active_level_q <= pwdata[0];
    end
  end

  bdlb_state #(
    .PATTERN_BITS(PATTERN_BITS)
  ) u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_item_i),
    .active_level_i(active_level_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= result;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty output register");

  a_no_result_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !accept |=> !out_valid_q)
    else $error("result appeared without an accepted item");

endmodule

FILE: verif/bdlb_checker.sv
`timescale 1ns / 1ps
// Checker for the button debounce and LED blink block: it watches both item
// channels and the register port, predicts every result and compares it.
// Depends on bdlb_pkg for the item structs, opcodes, masks and register index.
module bdlb_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  bdlb_pkg::in_t                  in_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  bdlb_pkg::out_t                 out_item_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [bdlb_pkg::AddrWidth-1:0] paddr_i,
  input  logic [bdlb_pkg::DataWidth-1:0] pwdata_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    changes_o,
  output int unsigned                    led_steps_o
);
  import bdlb_pkg::*;

  localparam logic [AddrWidth-1:0] ActiveLevelAddr = {RegActiveLevel, 2'b00};

  logic        level_cfg;
  logic [31:0] ms_now;
  logic        sample_armed;
  logic        blink_armed;
  logic        last_pressed;
  logic        debounced;
  logic [31:0] state_start;
  logic [31:0] cur_dur;
  logic [31:0] prev_dur;
  logic        led;
  logic [31:0] pattern;
  logic        pin_input;

  out_t        expected_status_q[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned changes;
  int unsigned led_steps;

  function automatic out_t predict_pin_status(in_t it);
    out_t res;
    logic pressed;
    logic lit;
    logic skip_led;
    skip_led = 1'b0;
    if (it.op == OpLoad) begin
      pattern = it.pattern_value;
    end else begin
      ms_now = ms_now + 32'd1;
      if (sample_armed && ((ms_now[4:0] & CheckMask) == '0)) begin
        pressed = (it.button_level == level_cfg);
        sample_armed = 1'b0;
        pin_input = 1'b1;
        if (pressed != last_pressed) begin
          last_pressed = pressed;
          skip_led = 1'b1;
        end else begin
          if (debounced != pressed) begin
            debounced = pressed;
            prev_dur = cur_dur + SampleSpanMs;
            state_start = ms_now;
            cur_dur = '0;
            changes++;
          end else begin
            cur_dur = ms_now - state_start;
          end
          pin_input = 1'b0;
        end
      end else if ((ms_now[4:0] & CheckMask) != '0) begin
        sample_armed = 1'b1;
      end
      if (!skip_led) begin
        if (blink_armed && ((ms_now[5:0] & StepMask) == '0)) begin
          lit = pattern[0];
          led = lit ? level_cfg : ~level_cfg;
          pattern = {lit, pattern[31:1]};
          blink_armed = 1'b0;
          led_steps++;
        end else if ((ms_now[5:0] & StepMask) != '0) begin
          blink_armed = 1'b1;
        end
      end
    end
    res.pin_as_input = pin_input;
    res.pin_level = pin_input ? 1'b1 : led;
    res.button_down = debounced;
    res.duration_ms = cur_dur;
    res.previous_duration_ms = prev_dur;
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_t exp_item;
    if (!rst_ni) begin
      level_cfg = 1'b1;
      ms_now = '0;
      sample_armed = 1'b0;
      blink_armed = 1'b0;
      last_pressed = 1'b0;
      debounced = 1'b0;
      state_start = '0;
      cur_dur = '0;
      prev_dur = '0;
      led = 1'b0;
      pattern = '0;
      pin_input = 1'b0;
      expected_status_q.delete();
      mismatches = 0;
      checked = 0;
      changes = 0;
      led_steps = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ActiveLevelAddr) begin
        level_cfg = pwdata_i[0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result item arrived with nothing expected", $realtime);
          end
        end else begin
          exp_item = expected_status_q.pop_front();
          checked++;
          if (out_item_i.pin_as_input !== exp_item.pin_as_input ||
              out_item_i.pin_level !== exp_item.pin_level ||
              out_item_i.button_down !== exp_item.button_down ||
              out_item_i.duration_ms !== exp_item.duration_ms ||
              out_item_i.previous_duration_ms !== exp_item.previous_duration_ms) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected input=%0b level=%0b down=%0b dur=%0d prev=%0d",
                       $realtime, exp_item.pin_as_input, exp_item.pin_level,
                       exp_item.button_down, exp_item.duration_ms,
                       exp_item.previous_duration_ms);
              $display("%0t:           got      input=%0b level=%0b down=%0b dur=%0d prev=%0d",
                       $realtime, out_item_i.pin_as_input, out_item_i.pin_level,
                       out_item_i.button_down, out_item_i.duration_ms,
                       out_item_i.previous_duration_ms);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_status_q.push_back(predict_pin_status(in_item_i));
      end
    end
    mismatches_o <= mismatches;
    pending_o <= expected_status_q.size();
    checked_o <= checked;
    changes_o <= changes;
    led_steps_o <= led_steps;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for the button debounce and LED blink block: it drives
// items and register writes under varying idle and stall patterns and gives the verdict.
// Depends on bdlb_pkg, bdlb_checker and the block itself.
module tb_top;
  import bdlb_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned DrainCycles = 3;
  localparam logic [AddrWidth-1:0] ActiveLevelAddr = {RegActiveLevel, 2'b00};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  int unsigned sent;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned changes;
  int unsigned led_steps;
  logic        held_level;

  button_debounce_led_blink u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bdlb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .changes_o    (changes),
    .led_steps_o  (led_steps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [31:0] random_pattern();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Button level holds for long stretches so that samples agree, with brief glitches.
  function in_t random_item();
    in_t it;
    it.op = ($urandom_range(0, 99) < 8) ? OpLoad : OpTick;
    if ($urandom_range(0, 69) == 0) begin
      held_level = ~held_level;
    end
    it.button_level = ($urandom_range(0, 29) == 0) ? ~held_level : held_level;
    it.pattern_value = random_pattern();
    return it;
  endfunction

  task automatic send_item(input in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sent++;
  endtask

  task automatic send_directed(input logic op, input logic level, input logic [31:0] pat);
    in_t it;
    it.op = op;
    it.button_level = level;
    it.pattern_value = pat;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_active_level(input logic level);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ActiveLevelAddr;
    pwdata <= {{(DataWidth-1){1'b0}}, level};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    out_ready_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    sent = 0;
    held_level = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed(OpTick, 1'b0, 32'h0000_0000);
    send_directed(OpTick, 1'b1, 32'hFFFF_FFFF);
    send_directed(OpLoad, 1'b0, 32'hFFFF_FFFF);
    send_directed(OpLoad, 1'b1, 32'h0000_0000);
    send_directed(OpLoad, 1'b0, 32'h8000_0001);
    send_directed(OpTick, 1'b1, 32'hA5A5_5A5A);
    send_directed(OpLoad, 1'b1, 32'h5A5A_A5A5);
    send_directed(OpTick, 1'b0, 32'h7FFF_FFFF);
    send_directed(OpLoad, 1'b0, 32'h0000_0001);
    send_directed(OpTick, 1'b1, 32'h8000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_active_level(phase[0] ? 1'b1 : 1'b0);
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 72;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 72;
        end
        default: begin
          idle_pct = 19;
          stall_pct = 19;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_item(random_item());
      end
    end

    wait_idle();
    $display("Sent %0d items and checked %0d results under four idle and stall mixes.",
             sent, checked);
    $display("Both active levels used; %0d debounced changes and %0d LED steps seen.",
             changes, led_steps);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: button_debounce_led_blink.f
rtl/core/bdlb_pkg.sv
rtl/core/bdlb_state.sv
rtl/core/button_debounce_led_blink.sv
verif/bdlb_checker.sv
verif/tb_top.sv
